// File: hdl/xkb64_pkg.sv
`default_nettype none

package xkb64_pkg;

  localparam int MAX_KEY_LENGTH = 8;
  localparam int KEY_POS_W      = $clog2(MAX_KEY_LENGTH);

  localparam logic [63:0] KEY_BYTES_RESET  = 64'h0000_006F_6C6C_6568;
  localparam logic [3:0]  KEY_LENGTH_RESET = 4'd5;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // configuration register indexes
  localparam logic CFG_KEY_BYTES  = 1'b0;
  localparam logic CFG_KEY_LENGTH = 1'b1;

  typedef logic [7:0] char_t;

  // standard base64 alphabet lookup
  function automatic char_t b64_char(input logic [5:0] v);
    char_t c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/xor_key_base64_encoder.sv
`default_nettype none
// a byte's first character appears on the output in the cycle after the byte is accepted
// throughput: one character transfer per cycle while out_stall is low; a byte yields one to four
//   characters (four thirds on average, four on a last byte in phase zero), a rate
//   set by the single-character output port draining a four-entry character register
// reset (rst, synchronous): key and key length return to "hello" / 5, message state clears,
//   the character register empties

module xor_key_base64_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration writes
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  // byte input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  // character output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_char,
  output logic             last_char
);

  localparam int PW = xkb64_pkg::KEY_POS_W;

  // configuration registers
  logic [63:0] key_bytes;
  logic [3:0]  key_length;

  // message state
  logic [PW-1:0] key_position;
  logic [1:0]    group_phase;
  logic [3:0]    carry_bits;

  // pending characters, chars[0] is the one on the output
  xkb64_pkg::char_t chars [4];
  logic [2:0]       cnt;
  logic             msg_last;

  logic in_xfer, out_xfer;

  assign out_valid = (cnt != 3'd0);
  assign out_char  = chars[0];
  // only the final pending character of a message-ending byte carries the flag
  assign last_char = msg_last && (cnt == 3'd1);
  assign out_xfer  = out_valid && !out_stall;

  // take a new byte once the pending characters are gone or the last one leaves now
  assign in_stall = !((cnt == 3'd0) || ((cnt == 3'd1) && out_xfer));
  assign in_xfer  = in_valid && !in_stall;

  // key selection and xor
  logic [3:0]    len_eff;
  logic [3:0]    pos_cur;
  logic [3:0]    pos_inc;
  logic [PW-1:0] key_position_next;
  logic [7:0]    key_byte;
  logic [7:0]    b;

  always_comb begin
    len_eff = (key_length > 4'(xkb64_pkg::MAX_KEY_LENGTH)) ?
              4'(xkb64_pkg::MAX_KEY_LENGTH) : key_length;
    pos_cur = {{(4-PW){1'b0}}, key_position};
    // out-of-range position after a length change falls back to key byte zero
    if (pos_cur >= len_eff) begin
      pos_cur = 4'd0;
    end
    pos_inc = pos_cur + 4'd1;
    if (pos_inc >= len_eff) begin
      pos_inc = 4'd0;
    end
    key_byte = key_bytes[8*pos_cur[PW-1:0] +: 8];
    if (len_eff == 4'd0) begin
      b                 = data_byte;
      key_position_next = key_position;
    end else begin
      b                 = data_byte ^ key_byte;
      key_position_next = pos_inc[PW-1:0];
    end
  end

  // base64 packing
  xkb64_pkg::char_t c_next [4];
  logic [2:0] cnt_next;
  logic [1:0] group_phase_next;
  logic [3:0] carry_bits_next;

  always_comb begin
    c_next[0]        = xkb64_pkg::PAD_CHAR;
    c_next[1]        = xkb64_pkg::PAD_CHAR;
    c_next[2]        = xkb64_pkg::PAD_CHAR;
    c_next[3]        = xkb64_pkg::PAD_CHAR;
    cnt_next         = 3'd1;
    group_phase_next = 2'd0;
    carry_bits_next  = 4'd0;
    case (group_phase)
      2'd1: begin
        c_next[0]        = xkb64_pkg::b64_char({carry_bits[1:0], b[7:4]});
        carry_bits_next  = b[3:0];
        group_phase_next = 2'd2;
        if (last_byte) begin
          c_next[1] = xkb64_pkg::b64_char({b[3:0], 2'b00});
          cnt_next  = 3'd3;
        end
      end
      2'd2: begin
        c_next[0] = xkb64_pkg::b64_char({carry_bits, b[7:6]});
        c_next[1] = xkb64_pkg::b64_char(b[5:0]);
        cnt_next  = 3'd2;
      end
      default: begin
        c_next[0]        = xkb64_pkg::b64_char(b[7:2]);
        carry_bits_next  = {2'b00, b[1:0]};
        group_phase_next = 2'd1;
        if (last_byte) begin
          c_next[1] = xkb64_pkg::b64_char({b[1:0], 4'b0000});
          cnt_next  = 3'd4;
        end
      end
    endcase
    // a message end restarts the group and the key
    if (last_byte) begin
      group_phase_next = 2'd0;
      carry_bits_next  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes    <= xkb64_pkg::KEY_BYTES_RESET;
      key_length   <= xkb64_pkg::KEY_LENGTH_RESET;
      key_position <= '0;
      group_phase  <= 2'd0;
      carry_bits   <= 4'd0;
      cnt          <= 3'd0;
      msg_last     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          xkb64_pkg::CFG_KEY_BYTES:  key_bytes  <= cfg_data;
          xkb64_pkg::CFG_KEY_LENGTH: key_length <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        key_position <= last_byte ? '0 : key_position_next;
        group_phase  <= group_phase_next;
        carry_bits   <= carry_bits_next;
        cnt          <= cnt_next;
        msg_last     <= last_byte;
      end else if (out_xfer) begin
        cnt <= cnt - 3'd1;
      end
    end
  end

  // character register: load on a byte transfer, shift down on a character transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      chars <= c_next;
    end else if (out_xfer) begin
      chars[0] <= chars[1];
      chars[1] <= chars[2];
      chars[2] <= chars[3];
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("pending character count out of range");

  a_phase_range: assert property (@(posedge clk) disable iff (rst) group_phase != 2'd3)
    else $error("group phase reached three");

  a_msg_restart: assert property (@(posedge clk) disable iff (rst)
    in_xfer && last_byte |=> group_phase == 2'd0 && carry_bits == 4'd0 && key_position == '0)
    else $error("message state not cleared after last byte");

  a_last_pad: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_char && $past(in_xfer) && $past(group_phase) != 2'd2
      |-> out_char == xkb64_pkg::PAD_CHAR)
    else $error("padded group does not end in pad character");
`endif

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_PCT     = 30;

  // directed table row kinds
  localparam logic ROW_BYTE = 1'b0;
  localparam logic ROW_CFG  = 1'b1;

  // base64 alphabet, sextet 0 in the top byte
  localparam logic [8*64-1:0] B64_SET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    xkb64_pkg::char_t ch;
    logic             fin;
  } char_expect_t;

  // one directed step: a byte transfer or a register write; n_typed > 0 means the
  // characters in txt (last one in the low byte) replace the predicted ones
  typedef struct packed {
    logic        kind;
    logic        cidx;
    logic [63:0] cval;
    logic [7:0]  d;
    logic        fin;
    logic [2:0]  n_typed;
    logic [31:0] txt;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_char;
  logic        last_char;

  // predictor copy of the registers and message state
  logic [63:0] key_word;
  logic [3:0]  key_len;
  logic [2:0]  key_pos;
  logic [1:0]  grp_phase;
  logic [3:0]  carry_nib;

  char_expect_t pending_chars[$];
  char_expect_t got_head;
  stim_row_t    stim_tab[$];

  int  mismatch_cnt = 0;
  int  cycle_cnt    = 0;
  bit  calm         = 1'b0;   // suppresses random idling on both sides
  bit  hold_req     = 1'b0;   // asks the receiver for a long hold-off

  xor_key_base64_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last_char (last_char)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic xkb64_pkg::char_t sextet_char(input logic [5:0] v);
    return B64_SET[8*(63 - v) +: 8];
  endfunction

  function automatic stim_row_t byte_row(input logic [7:0] d, input logic fin,
                                         input logic [2:0] n, input logic [31:0] txt);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_BYTE;
    r.d       = d;
    r.fin     = fin;
    r.n_typed = n;
    r.txt     = txt;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic idx, input logic [63:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cidx = idx;
    r.cval = val;
    return r;
  endfunction

  task automatic tab_add(input stim_row_t r);
    stim_tab = {stim_tab, r};
  endtask

  task automatic push_char(input xkb64_pkg::char_t c, input logic fin);
    char_expect_t e;
    e.ch  = c;
    e.fin = fin;
    pending_chars = {pending_chars, e};
  endtask

  // xor with the repeating key, then pack into base64 characters
  task automatic xor_encode(input logic [7:0] raw, input logic fin);
    logic [3:0] len;
    logic [3:0] pos;
    logic [7:0] b;
    len = key_len;
    if (len > xkb64_pkg::MAX_KEY_LENGTH) len = 4'(xkb64_pkg::MAX_KEY_LENGTH);
    b = raw;
    if (len != 4'd0) begin
      pos = {1'b0, key_pos};
      // stale position after a shorter key length falls back to key byte zero
      if (pos >= len) pos = 4'd0;
      b   = b ^ key_word[8*pos +: 8];
      pos = pos + 4'd1;
      if (pos >= len) pos = 4'd0;
      key_pos = pos[2:0];
    end
    case (grp_phase)
      2'd1: begin
        push_char(sextet_char({carry_nib[1:0], b[7:4]}), 1'b0);
        carry_nib = b[3:0];
        grp_phase = 2'd2;
        if (fin) begin
          push_char(sextet_char({carry_nib, 2'b00}), 1'b0);
          push_char(xkb64_pkg::PAD_CHAR, 1'b1);
        end
      end
      2'd2: begin
        push_char(sextet_char({carry_nib, b[7:6]}), 1'b0);
        push_char(sextet_char(b[5:0]), fin);
        carry_nib = 4'd0;
        grp_phase = 2'd0;
      end
      default: begin
        push_char(sextet_char(b[7:2]), 1'b0);
        carry_nib = {2'b00, b[1:0]};
        grp_phase = 2'd1;
        if (fin) begin
          push_char(sextet_char({carry_nib[1:0], 4'b0000}), 1'b0);
          push_char(xkb64_pkg::PAD_CHAR, 1'b0);
          push_char(xkb64_pkg::PAD_CHAR, 1'b1);
        end
      end
    endcase
    if (fin) begin
      key_pos   = 3'd0;
      grp_phase = 2'd0;
      carry_nib = 4'd0;
    end
  endtask

  // offer one byte, with random idle cycles ahead of it, until it transfers
  task automatic send_byte(input logic [7:0] d, input logic fin);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic feed(input logic [7:0] d, input logic fin);
    send_byte(d, fin);
    xor_encode(d, fin);
  endtask

  // stop offering and wait until every expected character has come out
  task automatic drain_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write; only called with the block drained
  task automatic cfg_put(input logic idx, input logic [63:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == xkb64_pkg::CFG_KEY_BYTES) key_word = val;
    else key_len = val[3:0];
  endtask

  // result checker: every character transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected transfer: out_char %h last_char %b", out_char, last_char);
        mismatch_cnt++;
      end else begin
        got_head = pending_chars.pop_front();
        if (out_char !== got_head.ch) begin
          $error("out_char: expected %h, actual %h", got_head.ch, out_char);
          mismatch_cnt++;
        end
        if (last_char !== got_head.fin) begin
          $error("last_char: expected %b, actual %b", got_head.fin, last_char);
          mismatch_cnt++;
        end
      end
    end
  end

  // receiver: random stalls, a long hold-off on request
  initial begin
    out_stall = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t   row;
    int          n0;
    int          total;
    int          in_phase;
    int          msg_len;
    logic [7:0]  d;
    logic [63:0] rnd;
    logic [3:0]  len;

    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = xkb64_pkg::CFG_KEY_BYTES;
    cfg_data  = '0;
    in_valid  = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    key_word  = xkb64_pkg::KEY_BYTES_RESET;
    key_len   = xkb64_pkg::KEY_LENGTH_RESET;
    key_pos   = '0;
    grp_phase = '0;
    carry_nib = '0;
    total     = 0;

    // --- directed table ---
    // reset key "hello" against "hello": every xor byte is zero
    tab_add(byte_row("h", 1'b0, 3'd1, "A"));
    tab_add(byte_row("e", 1'b0, 3'd1, "A"));
    tab_add(byte_row("l", 1'b0, 3'd2, "AA"));
    tab_add(byte_row("l", 1'b0, 3'd1, "A"));
    tab_add(byte_row("o", 1'b1, 3'd3, "AA="));
    // key length zero: plain base64, a message end in every phase, byte extremes
    tab_add(cfg_row(xkb64_pkg::CFG_KEY_LENGTH, 64'd0));
    tab_add(byte_row(8'h00, 1'b1, 3'd4, "AA=="));
    tab_add(byte_row(8'hFF, 1'b1, 3'd4, "/w=="));
    tab_add(byte_row(8'hFF, 1'b0, 3'd1, "/"));
    tab_add(byte_row(8'hFF, 1'b1, 3'd3, "/8="));
    tab_add(byte_row("M", 1'b0, 3'd1, "T"));
    tab_add(byte_row("a", 1'b0, 3'd1, "W"));
    tab_add(byte_row("n", 1'b1, 3'd2, "Fu"));
    // key length 15 saturates to eight; nine bytes wrap the key
    tab_add(cfg_row(xkb64_pkg::CFG_KEY_BYTES, 64'h0123_4567_89AB_CDEF));
    tab_add(cfg_row(xkb64_pkg::CFG_KEY_LENGTH, 64'd15));
    tab_add(byte_row(8'h00, 1'b0, 3'd0, 32'd0));
    tab_add(byte_row(8'hFF, 1'b0, 3'd0, 32'd0));
    tab_add(byte_row(8'h5A, 1'b0, 3'd0, 32'd0));
    tab_add(byte_row(8'hA5, 1'b0, 3'd0, 32'd0));
    tab_add(byte_row(8'h00, 1'b0, 3'd0, 32'd0));
    tab_add(byte_row(8'hFF, 1'b0, 3'd0, 32'd0));
    tab_add(byte_row(8'h3C, 1'b0, 3'd0, 32'd0));
    tab_add(byte_row(8'hC3, 1'b0, 3'd0, 32'd0));
    tab_add(byte_row(8'h00, 1'b1, 3'd0, 32'd0));
    // shorter key length mid-message: position three falls back to key byte zero
    tab_add(cfg_row(xkb64_pkg::CFG_KEY_BYTES, 64'h8877_6655_4433_2211));
    tab_add(cfg_row(xkb64_pkg::CFG_KEY_LENGTH, 64'd8));
    tab_add(byte_row(8'h00, 1'b0, 3'd0, 32'd0));
    tab_add(byte_row(8'h80, 1'b0, 3'd0, 32'd0));
    tab_add(byte_row(8'h7F, 1'b0, 3'd0, 32'd0));
    tab_add(cfg_row(xkb64_pkg::CFG_KEY_LENGTH, 64'd3));
    tab_add(byte_row(8'h12, 1'b0, 3'd0, 32'd0));
    tab_add(byte_row(8'hFE, 1'b1, 3'd0, 32'd0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_tab[i]) begin
      row = stim_tab[i];
      if (row.kind == ROW_CFG) begin
        drain_wait();
        cfg_put(row.cidx, row.cval);
      end else begin
        send_byte(row.d, row.fin);
        n0 = pending_chars.size();
        xor_encode(row.d, row.fin);
        if (row.n_typed != 3'd0) begin
          // hand-written characters take the place of the predicted ones
          while (pending_chars.size() > n0) void'(pending_chars.pop_back());
          for (int k = 0; k < row.n_typed; k++)
            push_char(row.txt[8*(row.n_typed - 1 - k) +: 8],
                      row.fin && (k == row.n_typed - 1));
        end
        total++;
      end
    end

    // --- random part: phases of well-formed messages under varied keys ---
    for (int ph = 0; ph < 10; ph++) begin
      drain_wait();
      rnd = {$urandom, $urandom};
      case (ph)
        0: begin
          cfg_put(xkb64_pkg::CFG_KEY_BYTES, '1);
          cfg_put(xkb64_pkg::CFG_KEY_LENGTH, 64'd8);
        end
        1: begin
          cfg_put(xkb64_pkg::CFG_KEY_BYTES, '0);
          cfg_put(xkb64_pkg::CFG_KEY_LENGTH, 64'd15);
        end
        2: begin
          cfg_put(xkb64_pkg::CFG_KEY_BYTES, rnd);
          cfg_put(xkb64_pkg::CFG_KEY_LENGTH, 64'd0);
        end
        3: begin
          cfg_put(xkb64_pkg::CFG_KEY_BYTES, rnd);
          cfg_put(xkb64_pkg::CFG_KEY_LENGTH, 64'd1);
        end
        default: begin
          cfg_put(xkb64_pkg::CFG_KEY_BYTES, rnd);
          // upper data bits are don't-care for the length register
          len = 4'($urandom_range(15));
          cfg_put(xkb64_pkg::CFG_KEY_LENGTH, {rnd[63:4] ^ 60'h5A5A5A5A5A5A5A5, len});
        end
      endcase

      in_phase = 0;
      while (in_phase < 40) begin
        msg_len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (int i = 0; i < msg_len; i++) begin
          case ($urandom_range(9))
            0:       d = 8'h00;
            1:       d = 8'hFF;
            default: d = 8'($urandom);
          endcase
          feed(d, i == msg_len - 1);
          in_phase++;
          total++;
          // long receiver hold-off while bytes keep coming
          if (total == 60) hold_req = 1'b1;
          // a stretch with no idling on either side
          calm = (total >= 150 && total < 230);
          // occasional key length change inside a message
          if (i != msg_len - 1 && $urandom_range(99) < 3) begin
            drain_wait();
            cfg_put(xkb64_pkg::CFG_KEY_LENGTH, 64'($urandom_range(15)));
          end
        end
      end
    end

    drain_wait();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
